// ===== hdl/opgf_pkg.sv =====
// ----------------------------------------------------------------------------
// opgf_pkg: shared types and constants of the op-amp gain, filter, slew and
// clip unit.
// Holds the register codes, reset values, datapath widths, controller states
// and the command and configuration structs used by every module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package opgf_pkg;

  // Configuration register widths.
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned COEFF_W    = 16;
  localparam int unsigned STEP_W     = 23;
  localparam int unsigned VOUT_W     = 23;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Fraction bits of the gain.
  localparam int unsigned GAIN_FRAC_BITS = 12;

  // Internal datapath widths.
  localparam int unsigned SAT_W  = 48;                    // saturated gain value
  localparam int unsigned WNEW_W = COEFF_W + 1;           // 65536 - coeff
  localparam int unsigned HIST_W = COEFF_W + 1 + VOUT_W;  // coeff * last output
  localparam int unsigned SUM_W  = SAT_W + WNEW_W + 1;    // smoothing sum
  localparam int unsigned CHG_W  = SAT_W + 1;             // change from last output

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 32'd4096;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd0;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 23'd8388607;

  // Saturation limits of the gain value and the output rails.
  localparam logic signed [SAT_W-1:0] SAT_MAX = {1'b0, {(SAT_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_MIN = {1'b1, {(SAT_W-1){1'b0}}};
  localparam logic signed [SAT_W-1:0] RAIL_HI = 48'sd3932160;
  localparam logic signed [SAT_W-1:0] RAIL_LO = -48'sd3932160;

  // Full weight of the smoothing step, 1.0 in Q1.16.
  localparam logic [WNEW_W-1:0] WEIGHT_ONE = 17'd65536;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAIN,
    ST_SMOOTH,
    ST_FINISH
  } opgf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic gain;
    logic smooth;
    logic finish;
  } opgf_cmd_t;

  // Current configuration.
  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [COEFF_W-1:0] coeff;
    logic [STEP_W-1:0]  max_step;
  } opgf_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/opgf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// opgf_cfg_regs: configuration registers.
// Decodes writes on the configuration channel into the gain, smoothing
// coefficient and maximum step registers. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opgf_cfg_regs import opgf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output      opgf_cfg_t             cfg_o
);

  opgf_cfg_t cfg_q, cfg_d;

  // The registers take a write in every cycle.
  assign cfg_ready_o = 1'b1;

  // Write decode; values are cut to the register widths.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GAIN:  cfg_d.gain     = cfg_data_i[GAIN_W-1:0];
        REG_COEFF: cfg_d.coeff    = cfg_data_i[COEFF_W-1:0];
        REG_STEP:  cfg_d.max_step = cfg_data_i[STEP_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain     <= GAIN_RESET;
      cfg_q.coeff    <= COEFF_RESET;
      cfg_q.max_step <= STEP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/opgf_ctrl.sv =====
// ----------------------------------------------------------------------------
// opgf_ctrl: sequence controller.
// Steps each item through the gain, smoothing and finishing cycles and owns
// the handshakes of the input and output channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opgf_ctrl import opgf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_stall_o,
  output      logic out_valid_o,
  input  wire logic out_stall_i,
  output      opgf_cmd_t cmd_o
);

  opgf_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The result register may be loaded once its item is gone or being taken.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/opgf_datapath.sv =====
// ----------------------------------------------------------------------------
// opgf_datapath: arithmetic of the unit.
// Difference, gain with 48-bit saturation, one-pole smoothing, slew limit and
// rail clamp; registers after difference, gain and smoothing, then last output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opgf_datapath import opgf_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire opgf_cmd_t                     cmd_i,
  input  wire opgf_cfg_t                     cfg_i,
  input  wire logic signed [SAMPLE_BITS-1:0] v_plus_i,
  input  wire logic signed [SAMPLE_BITS-1:0] v_minus_i,
  output      logic signed [VOUT_W-1:0]      v_out_o
);

  localparam int unsigned MAG_W  = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = MAG_W + GAIN_W;

  // Registers.
  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic [PROD_W-1:0]        prod_q;
  logic signed [HIST_W-1:0] hist_q;
  logic signed [SUM_W-1:0]  mix_q;
  logic signed [VOUT_W-1:0] last_q, last_d;

  // Input step signals.
  logic signed [MAG_W-1:0]  plus_ext, minus_ext, diff_pm, diff_mp;

  // Smoothing step signals.
  logic [PROD_W-1:0]        shifted;
  logic                     ovf;
  logic signed [SAT_W-1:0]  gained;
  logic [WNEW_W-1:0]        w_new;

  // Finishing step signals.
  logic signed [SUM_W-1:0]  sum;
  logic                     rnd;
  logic signed [SAT_W-1:0]  smoothed, slewed, railed;
  logic signed [CHG_W-1:0]  change, step_pos, step_neg;
  logic signed [SAT_W-1:0]  last_ext, step_ext;

  // Both differences at once; the sign of the first picks the magnitude.
  always_comb begin
    plus_ext  = {v_plus_i[SAMPLE_BITS-1], v_plus_i};
    minus_ext = {v_minus_i[SAMPLE_BITS-1], v_minus_i};
    diff_pm   = plus_ext - minus_ext;
    diff_mp   = minus_ext - plus_ext;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      neg_q <= diff_pm[MAG_W-1];
      mag_q <= diff_pm[MAG_W-1] ? diff_mp : diff_pm;
    end
  end

  // Gain product, and the weighted last output alongside it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.gain) begin
      prod_q <= {{GAIN_W{1'b0}}, mag_q} * {{MAG_W{1'b0}}, cfg_i.gain};
      hist_q <= $signed({1'b0, cfg_i.coeff}) * last_q;
    end
  end

  // Drop the gain fraction, saturate to 48 bits and apply the sign.
  always_comb begin
    shifted = prod_q >> GAIN_FRAC_BITS;
    ovf     = |shifted[PROD_W-1:SAT_W-1];
    if (ovf) begin
      gained = neg_q ? SAT_MIN : SAT_MAX;
    end else if (neg_q) begin
      gained = -$signed({1'b0, shifted[SAT_W-2:0]});
    end else begin
      gained = $signed({1'b0, shifted[SAT_W-2:0]});
    end
    w_new = WEIGHT_ONE - {1'b0, cfg_i.coeff};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smooth) begin
      mix_q <= gained * $signed({1'b0, w_new});
    end
  end

  // Sum, divide by 65536 toward zero, limit the slew and clamp to the rails.
  always_comb begin
    sum      = mix_q + $signed({{(SUM_W-HIST_W){hist_q[HIST_W-1]}}, hist_q});
    rnd      = sum[SUM_W-1] && (sum[15:0] != 16'd0);
    smoothed = $signed(sum[SAT_W+15:16]) + $signed({{(SAT_W-1){1'b0}}, rnd});

    last_ext = $signed({{(SAT_W-VOUT_W){last_q[VOUT_W-1]}}, last_q});
    step_ext = $signed({{(SAT_W-STEP_W){1'b0}}, cfg_i.max_step});
    change   = $signed({smoothed[SAT_W-1], smoothed})
             - $signed({last_ext[SAT_W-1], last_ext});
    step_pos = $signed({{(CHG_W-STEP_W){1'b0}}, cfg_i.max_step});
    step_neg = -step_pos;

    if (change > step_pos) begin
      slewed = last_ext + step_ext;
    end else if (change < step_neg) begin
      slewed = last_ext - step_ext;
    end else begin
      slewed = smoothed;
    end

    if (slewed > RAIL_HI) begin
      railed = RAIL_HI;
    end else if (slewed < RAIL_LO) begin
      railed = RAIL_LO;
    end else begin
      railed = slewed;
    end

    last_d = cmd_i.finish ? railed[VOUT_W-1:0] : last_q;
  end

  // The last output doubles as the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

  assign v_out_o = last_q;

endmodule

`default_nettype wire

// ===== hdl/opamp_gain_filter_slew_clip_unit.sv =====
// ----------------------------------------------------------------------------
// opamp_gain_filter_slew_clip_unit: behavioural op-amp, one output per sample.
// Gain on the input difference with 48-bit saturation, one-pole smoothing
// toward the last output, slew limit and clamp to the +-15 V rails.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid_i, in_stall_o, v_plus_i, v_minus_i | in
//   output  | out_valid_o, out_stall_i, v_out_o           | out
//   config  | cfg_valid_i, cfg_ready_o, cfg_index_i,      | in
//           | cfg_data_i                                  |
//
// An item passes through the accept cycle, the gain multiply, the smoothing
// multiply and the finishing cycle, and a new item is accepted only once the
// last one is finished. The feedback through the last output requires this.
// Reset clears the controller, the last output and the registers to their
// defaults. A stalled result holds the finishing cycle until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opamp_gain_filter_slew_clip_unit import opgf_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] v_plus_i,
  input  wire logic signed [SAMPLE_BITS-1:0] v_minus_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic signed [VOUT_W-1:0]      v_out_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i
);

  opgf_cmd_t cmd;
  opgf_cfg_t cfg;

  // Configuration registers.
  opgf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequence controller.
  opgf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Arithmetic.
  opgf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cfg_i     (cfg),
    .v_plus_i  (v_plus_i),
    .v_minus_i (v_minus_i),
    .v_out_o   (v_out_o)
  );

endmodule

`default_nettype wire
